FILE: sv/pcts_pkg.sv
package pcts_pkg;

    localparam int TASK_SLOTS_DEFAULT = 8;

    // Fixed field widths
    localparam int TASK_W  = 3;
    localparam int CNT_W   = 9;
    localparam int PRI_W   = 8;
    localparam int MASK_W  = 8;
    localparam int PRIO_W  = 64;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TASK_PRIORITIES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESENT_MASK    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RUNNABLE_MASK   = 2'd2;

    // Configuration reset values
    localparam logic [PRIO_W-1:0] PRIO_RESET     = '0;
    localparam logic [MASK_W-1:0] PRESENT_RESET  = 8'hFE;
    localparam logic [MASK_W-1:0] RUNNABLE_RESET = 8'hFE;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHARGE,
        ST_SCAN_START,
        ST_SCAN,
        ST_REFILL_START,
        ST_REFILL,
        ST_FETCH,
        ST_REPORT,
        ST_DONE
    } pcts_state_t;

    typedef struct packed {
        logic              valid;
        logic [TASK_W-1:0] running_task;
        logic              switched;
        logic [CNT_W-1:0]  running_counter;
        logic              refilled;
        logic              stuck;
    } pcts_result_t;

endpackage

FILE: sv/pcts_ram.sv
module pcts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     wen,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     ren,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (wen)
        begin
            mem[waddr] <= wdata;
        end
        if (ren)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: sv/pcts_seq.sv
module pcts_seq
    import pcts_pkg::*;
#(
    parameter int TASK_SLOTS = TASK_SLOTS_DEFAULT,
    localparam int AW = $clog2(TASK_SLOTS)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              tick,
    input  logic [PRIO_W-1:0] task_priorities,
    input  logic [MASK_W-1:0] present_mask,
    input  logic [MASK_W-1:0] runnable_mask,
    input  logic [CNT_W-1:0]  mem_rdata,
    output logic              mem_ren,
    output logic [AW-1:0]     mem_raddr,
    output logic              mem_wen,
    output logic [AW-1:0]     mem_waddr,
    output logic [CNT_W-1:0]  mem_wdata,
    output logic              idle,
    input  logic              result_take,
    output pcts_result_t      result
);

    localparam logic [AW-1:0] LAST_SLOT  = AW'(TASK_SLOTS - 1);
    localparam logic [AW-1:0] FIRST_SLOT = AW'(1);

    pcts_state_t state_reg, state_next;

    logic             tick_reg, tick_next;
    logic [AW-1:0]    cur_reg, cur_next;
    logic [AW-1:0]    prev_reg, prev_next;
    logic [AW-1:0]    idx_reg, idx_next;
    logic             found_reg, found_next;
    logic [AW-1:0]    best_reg, best_next;
    logic [CNT_W-1:0] max_reg, max_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             refilled_reg, refilled_next;
    logic             stuck_reg, stuck_next;

    logic             cur_busy;
    logic [CNT_W-1:0] dec_val;
    logic             eligible;
    logic             take_slot;
    logic             found_upd;
    logic [AW-1:0]    best_upd;
    logic [CNT_W-1:0] max_upd;
    logic             scan_last;
    logic [PRI_W-1:0] pri_sel;
    logic [CNT_W-1:0] refill_val;

    // Scan and refill datapath
    always_comb
    begin
        cur_busy   = (cur_reg != '0);
        dec_val    = (mem_rdata == '0) ? '0 : mem_rdata - CNT_W'(1);
        eligible   = present_mask[idx_reg] & runnable_mask[idx_reg];
        take_slot  = eligible && (!found_reg || (mem_rdata > max_reg));
        found_upd  = found_reg | eligible;
        best_upd   = take_slot ? idx_reg : best_reg;
        max_upd    = take_slot ? mem_rdata : max_reg;
        scan_last  = (idx_reg == FIRST_SLOT);
        pri_sel    = task_priorities[PRI_W * idx_reg +: PRI_W];
        refill_val = {1'b0, mem_rdata[CNT_W-1:1]} + CNT_W'(pri_sel);
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_CHARGE;
                end
            end
            ST_CHARGE:
            begin
                if (!tick_reg || (cur_busy && dec_val != '0))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_SCAN_START;
                end
            end
            ST_SCAN_START:
            begin
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (scan_last)
                begin
                    if (found_upd && max_upd == '0 && !refilled_reg)
                    begin
                        state_next = ST_REFILL_START;
                    end
                    else
                    begin
                        state_next = ST_FETCH;
                    end
                end
            end
            ST_REFILL_START:
            begin
                state_next = ST_REFILL;
            end
            ST_REFILL:
            begin
                if (idx_reg == LAST_SLOT)
                begin
                    state_next = ST_SCAN_START;
                end
            end
            ST_FETCH:
            begin
                state_next = ST_REPORT;
            end
            ST_REPORT:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (result_take)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Memory port and handshake outputs
    always_comb
    begin
        mem_ren   = 1'b0;
        mem_raddr = cur_reg;
        mem_wen   = 1'b0;
        mem_waddr = cur_reg;
        mem_wdata = dec_val;
        unique case (state_reg)
            ST_IDLE:
            begin
                mem_ren = start;
            end
            ST_CHARGE:
            begin
                mem_wen = tick_reg && cur_busy;
            end
            ST_SCAN_START:
            begin
                mem_ren   = 1'b1;
                mem_raddr = LAST_SLOT;
            end
            ST_SCAN:
            begin
                mem_ren   = !scan_last;
                mem_raddr = idx_reg - AW'(1);
            end
            ST_REFILL_START:
            begin
                mem_ren   = 1'b1;
                mem_raddr = FIRST_SLOT;
            end
            ST_REFILL:
            begin
                mem_wen   = present_mask[idx_reg];
                mem_waddr = idx_reg;
                mem_wdata = refill_val;
                mem_ren   = (idx_reg != LAST_SLOT);
                mem_raddr = idx_reg + AW'(1);
            end
            ST_FETCH:
            begin
                mem_ren = 1'b1;
            end
            ST_REPORT, ST_DONE:
            begin
                mem_ren = 1'b0;
            end
            default:
            begin
                mem_ren = 1'b0;
            end
        endcase

        idle                   = (state_reg == ST_IDLE);
        result.valid           = (state_reg == ST_DONE);
        result.running_task    = TASK_W'(cur_reg);
        result.switched        = (cur_reg != prev_reg);
        result.running_counter = cnt_reg;
        result.refilled        = refilled_reg;
        result.stuck           = stuck_reg;
    end

    // Working registers
    always_comb
    begin
        tick_next     = tick_reg;
        cur_next      = cur_reg;
        prev_next     = prev_reg;
        idx_next      = idx_reg;
        found_next    = found_reg;
        best_next     = best_reg;
        max_next      = max_reg;
        cnt_next      = cnt_reg;
        refilled_next = refilled_reg;
        stuck_next    = stuck_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    tick_next     = tick;
                    prev_next     = cur_reg;
                    refilled_next = 1'b0;
                    stuck_next    = 1'b0;
                end
            end
            ST_CHARGE:
            begin
                cnt_next = (tick_reg && cur_busy) ? dec_val : mem_rdata;
            end
            ST_SCAN_START:
            begin
                idx_next   = LAST_SLOT;
                found_next = 1'b0;
                best_next  = '0;
                max_next   = '0;
            end
            ST_SCAN:
            begin
                found_next = found_upd;
                best_next  = best_upd;
                max_next   = max_upd;
                if (!scan_last)
                begin
                    idx_next = idx_reg - AW'(1);
                end
                else if (!found_upd)
                begin
                    cur_next = '0;
                end
                else if (max_upd != '0)
                begin
                    cur_next = best_upd;
                end
                else if (refilled_reg)
                begin
                    // hold the current task
                    stuck_next = 1'b1;
                end
                else
                begin
                    refilled_next = 1'b1;
                end
            end
            ST_REFILL_START:
            begin
                idx_next = FIRST_SLOT;
            end
            ST_REFILL:
            begin
                if (idx_reg != LAST_SLOT)
                begin
                    idx_next = idx_reg + AW'(1);
                end
            end
            ST_REPORT:
            begin
                cnt_next = mem_rdata;
            end
            ST_FETCH, ST_DONE:
            begin
                cnt_next = cnt_reg;
            end
            default:
            begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            cur_reg      <= '0;
            refilled_reg <= 1'b0;
            stuck_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cur_reg      <= cur_next;
            refilled_reg <= refilled_next;
            stuck_reg    <= stuck_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tick_reg  <= tick_next;
        prev_reg  <= prev_next;
        idx_reg   <= idx_next;
        found_reg <= found_next;
        best_reg  <= best_next;
        max_reg   <= max_next;
        cnt_reg   <= cnt_next;
    end

`ifndef SYNTHESIS
    a_no_same_entry_rw: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_wen && mem_ren) |-> (mem_waddr != mem_raddr))
        else $error("read and write of the same counter entry in one cycle");

    a_stuck_after_refill: assert property (@(posedge clk) disable iff (!rst_n)
        stuck_reg |-> refilled_reg)
        else $error("stuck raised without a refill");

    a_scan_skips_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN || state_reg == ST_REFILL) |-> (idx_reg != '0))
        else $error("scan or refill reached the idle slot");

    a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && !result_take) |=> (state_reg == ST_DONE && $stable(cur_reg)))
        else $error("result dropped while the output was full");
`endif

endmodule

FILE: sv/priority_counter_task_scheduler_top.sv
// Channel    Direction  Handshake              Payload
// in         input      in_valid / in_stall    tick
// out        output     out_valid / out_stall  running_task, switched, running_counter,
//                                              refilled, stuck
// cfg        input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A status item or a tick that needs no new pick goes from the charge step to the result.
// A tick that triggers a pick also scans the slots from the last down to slot 1 and then
// fetches the picked task's counter; one that also refills present tasks' counters from
// slot 1 up rescans after the refill; the RAM's single read port takes one slot per cycle.
// Reset clears the sequencer and the valid bits and sets the configuration to its reset
// values; unwritten counter RAM entries read as zero, so no clearing pass is needed.
// A new item is taken while a finished result still waits in the output register.
module priority_counter_task_scheduler_top
    import pcts_pkg::*;
#(
    parameter int TASK_SLOTS = TASK_SLOTS_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 tick,

    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [TASK_W-1:0]    running_task,
    output logic                 switched,
    output logic [CNT_W-1:0]     running_counter,
    output logic                 refilled,
    output logic                 stuck,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [PRIO_W-1:0]    cfg_data
);

    localparam int AW = $clog2(TASK_SLOTS);

    // Configuration registers
    logic [PRIO_W-1:0] prio_reg;
    logic [MASK_W-1:0] present_reg;
    logic [MASK_W-1:0] runnable_reg;

    // Counter RAM port
    logic             mem_ren;
    logic [AW-1:0]    mem_raddr;
    logic             mem_wen;
    logic [AW-1:0]    mem_waddr;
    logic [CNT_W-1:0] mem_wdata;
    logic [CNT_W-1:0] ram_rdata;
    logic [CNT_W-1:0] cnt_rdata;

    // One valid bit per counter entry; an unwritten entry reads as zero
    logic [TASK_SLOTS-1:0] written_reg;
    logic                  rd_written_reg;

    logic         seq_idle;
    logic         in_accept;
    logic         result_take;
    pcts_result_t result;

    // Output register
    logic              out_valid_reg;
    logic [TASK_W-1:0] out_task_reg;
    logic              out_switched_reg;
    logic [CNT_W-1:0]  out_counter_reg;
    logic              out_refilled_reg;
    logic              out_stuck_reg;

    assign cfg_ready   = 1'b1;
    assign in_stall    = !seq_idle;
    assign in_accept   = in_valid && !in_stall;
    // take the result when the output register is empty or being drained
    assign result_take = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prio_reg     <= PRIO_RESET;
            present_reg  <= PRESENT_RESET;
            runnable_reg <= RUNNABLE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_TASK_PRIORITIES: prio_reg     <= cfg_data;
                CFG_PRESENT_MASK:    present_reg  <= cfg_data[MASK_W-1:0];
                CFG_RUNNABLE_MASK:   runnable_reg <= cfg_data[MASK_W-1:0];
                default:             prio_reg     <= prio_reg;  // drop unknown index
            endcase
        end
    end

    pcts_ram #(
        .WIDTH (CNT_W),
        .DEPTH (TASK_SLOTS)
    ) u_counter_ram (
        .clk   (clk),
        .wen   (mem_wen),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .ren   (mem_ren),
        .raddr (mem_raddr),
        .rdata (ram_rdata)
    );

    // Track written entries and register the flag alongside the read data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg <= '0;
        end
        else if (mem_wen)
        begin
            written_reg[mem_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_ren)
        begin
            rd_written_reg <= written_reg[mem_raddr];
        end
    end

    assign cnt_rdata = rd_written_reg ? ram_rdata : '0;

    pcts_seq #(
        .TASK_SLOTS (TASK_SLOTS)
    ) u_seq (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (in_accept),
        .tick            (tick),
        .task_priorities (prio_reg),
        .present_mask    (present_reg),
        .runnable_mask   (runnable_reg),
        .mem_rdata       (cnt_rdata),
        .mem_ren         (mem_ren),
        .mem_raddr       (mem_raddr),
        .mem_wen         (mem_wen),
        .mem_waddr       (mem_waddr),
        .mem_wdata       (mem_wdata),
        .idle            (seq_idle),
        .result_take     (result_take),
        .result          (result)
    );

    // Output register: load on a finished result, clear once transferred
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (result.valid && result_take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (result.valid && result_take)
        begin
            out_task_reg     <= result.running_task;
            out_switched_reg <= result.switched;
            out_counter_reg  <= result.running_counter;
            out_refilled_reg <= result.refilled;
            out_stuck_reg    <= result.stuck;
        end
    end

    assign out_valid       = out_valid_reg;
    assign running_task    = out_task_reg;
    assign switched        = out_switched_reg;
    assign running_counter = out_counter_reg;
    assign refilled        = out_refilled_reg;
    assign stuck           = out_stuck_reg;

endmodule
